// ===== rtl/xmcrc_pkg.sv =====
package xmcrc_pkg;

    // field widths
    localparam int DATA_W = 8;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 11;
    localparam int PKT_W  = 16;
    localparam int CRC_W  = 16;
    localparam int POS_W  = 8;

    // block geometry, fixed by the protocol
    localparam int BLOCK_BYTES = 128;
    localparam int BLOCK_SHIFT = 7;

    // command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    // reply codes
    localparam logic REPLY_ACK = 1'b0;
    localparam logic REPLY_NAK = 1'b1;

    // protocol bytes and frame positions
    localparam logic [DATA_W-1:0] SOH_BYTE       = 8'h01;
    localparam logic [DATA_W-1:0] EOT_BYTE       = 8'h04;
    localparam logic [POS_W-1:0]  CRC_FIRST_POS  = 8'd3;
    localparam logic [POS_W-1:0]  CRC_LAST_POS   = 8'd130;
    localparam logic [POS_W-1:0]  TRAILER_HI_POS = 8'd131;
    localparam logic [POS_W-1:0]  FRAME_LAST_POS = 8'd132;
    localparam logic [POS_W-1:0]  POS_MAX        = 8'hFF;

    // crc-16/xmodem
    localparam logic [CRC_W-1:0] XMODEM_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] XMODEM_SEED = 16'h0000;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] data_byte;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        logic              reply;
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [LEN_W-1:0]  write_length;
        logic              session_done;
        logic [PKT_W-1:0]  packet_count;
    } result_t;

    // one byte through the crc, msb first
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [DATA_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ XMODEM_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/xmcrc_stream_if.sv =====
interface xmcrc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/xmodem_crc_frame_receiver.sv =====
// a byte that ends a frame gives its reply through the input register and then the result register
// throughput: one byte per cycle while the reply side is ready
// the crc runs one byte per cycle while the input register moves on, through eight unrolled shift steps
// reset: asynchronous, active low; session idle, counts, crc and base address cleared
module xmodem_crc_frame_receiver
    import xmcrc_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [ADDR_W-1:0]   cfg_data,
    xmcrc_stream_if.sink        frames,
    xmcrc_stream_if.source      replies
);

    in_item_t item;
    result_t  res;

    // pack the byte transfer
    assign item.command   = frames.payload.command;
    assign item.data_byte = frames.payload.data_byte;
    assign item.frame_end = frames.payload.frame_end;

    // frame checking and page address generation
    xmcrc_frame_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .item_valid (frames.valid),
        .item_ready (frames.ready),
        .item       (item),
        .res_valid  (replies.valid),
        .res_ready  (replies.ready),
        .res        (res)
    );

    // unpack the reply transfer
    assign replies.payload.reply         = res.reply;
    assign replies.payload.write_valid   = res.write_valid;
    assign replies.payload.write_address = res.write_address;
    assign replies.payload.write_length  = res.write_length;
    assign replies.payload.session_done  = res.session_done;
    assign replies.payload.packet_count  = res.packet_count;

    // a waiting reply holds still until taken
    a_reply_stable: assert property (@(posedge clk) disable iff (!rst_n)
        replies.valid && !replies.ready |=> replies.valid && $stable(replies.payload))
        else $error("reply changed while waiting");

    // without a page write the address and length stay clear
    a_no_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        replies.valid && !replies.payload.write_valid
        |-> (replies.payload.write_address == '0) && (replies.payload.write_length == '0))
        else $error("write fields set without a page write");

    // the end of a session is always acknowledged
    a_done_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
        replies.valid && replies.payload.session_done |-> replies.payload.reply == REPLY_ACK)
        else $error("session end not acknowledged");

endmodule

// ===== rtl/xmcrc_frame_core.sv =====
module xmcrc_frame_core
    import xmcrc_pkg::*;
#(
    parameter int PAGE_BYTES = 1024
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [ADDR_W-1:0]  cfg_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  in_item_t           item,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam int BPP   = ((PAGE_BYTES / BLOCK_BYTES) > 0) ? (PAGE_BYTES / BLOCK_BYTES) : 1;
    localparam int REM_W = $clog2(BPP + 1);
    localparam int OFF_W = PKT_W + $clog2(PAGE_BYTES + 1);
    localparam int PART_W = REM_W + BLOCK_SHIFT;
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(BPP - 1);
    localparam logic [OFF_W-1:0] OFF_STEP = OFF_W'(PAGE_BYTES);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PAGE_BYTES);
    localparam logic [PKT_W-1:0] PKT_MAX  = {PKT_W{1'b1}};

    // configuration
    logic [ADDR_W-1:0] base_reg;

    // input register
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // session state
    logic              session_reg, session_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic              soh_reg, soh_next;
    logic [DATA_W-1:0] trail_hi_reg, trail_hi_next;
    logic [PKT_W-1:0]  count_reg, count_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [OFF_W-1:0]  off_reg, off_next;

    // result register
    logic    out_valid_reg;
    result_t out_reg;

    logic              s1_answer;
    logic              s1_fire;
    logic              data_frame;
    logic              eot_frame;
    logic              crc_ok;
    logic [ADDR_W-1:0] page_address;
    logic [PART_W-1:0] part_bytes;
    result_t           res_next;

    // base address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (cfg_write)
            base_reg <= cfg_data;
    end

    // frame decode on the registered item
    assign data_frame   = (pos_reg == FRAME_LAST_POS) && soh_reg;
    assign eot_frame    = (pos_reg == '0) && (s1_item_reg.data_byte == EOT_BYTE);
    assign crc_ok       = (crc_reg == {trail_hi_reg, s1_item_reg.data_byte});
    assign s1_answer    = (s1_item_reg.command == CMD_BYTE) && session_reg
                          && s1_item_reg.frame_end && (data_frame || eot_frame);
    assign page_address = base_reg + ADDR_W'(off_reg);
    assign part_bytes   = {rem_reg, BLOCK_SHIFT'(0)};

    // handshake: the stage moves on when its result, if any, has a free slot
    assign s1_fire    = s1_valid_reg && (!s1_answer || !out_valid_reg || res_ready);
    assign item_ready = !s1_valid_reg || s1_fire;

    // next state and result
    always_comb
    begin
        session_next  = session_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        soh_next      = soh_reg;
        trail_hi_next = trail_hi_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        off_next      = off_reg;
        res_next      = '0;

        if (s1_item_reg.command == CMD_ARM)
        begin
            session_next  = 1'b1;
            pos_next      = '0;
            crc_next      = XMODEM_SEED;
            soh_next      = 1'b0;
            trail_hi_next = '0;
            count_next    = '0;
            rem_next      = '0;
            off_next      = '0;
        end
        else if (session_reg)
        begin
            // byte bookkeeping
            if (pos_reg == '0)
                soh_next = (s1_item_reg.data_byte == SOH_BYTE);
            if (pos_reg >= CRC_FIRST_POS && pos_reg <= CRC_LAST_POS)
                crc_next = crc16_byte(crc_reg, s1_item_reg.data_byte);
            if (pos_reg == TRAILER_HI_POS)
                trail_hi_next = s1_item_reg.data_byte;
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;

            // end of frame
            if (s1_item_reg.frame_end)
            begin
                pos_next      = '0;
                crc_next      = XMODEM_SEED;
                soh_next      = 1'b0;
                trail_hi_next = '0;
                if (data_frame)
                begin
                    if (crc_ok)
                    begin
                        count_next = count_reg + 1'b1;
                        if (count_reg == PKT_MAX || rem_reg == REM_LAST)
                        begin
                            res_next.write_valid   = 1'b1;
                            res_next.write_address = page_address;
                            res_next.write_length  = LEN_FULL;
                            rem_next = '0;
                            off_next = (count_reg == PKT_MAX) ? '0 : off_reg + OFF_STEP;
                        end
                        else
                        begin
                            rem_next = rem_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_next.reply = REPLY_NAK;
                    end
                end
                else if (eot_frame)
                begin
                    if (rem_reg != '0)
                    begin
                        res_next.write_valid   = 1'b1;
                        res_next.write_address = page_address;
                        res_next.write_length  = LEN_W'(part_bytes);
                    end
                    res_next.session_done = 1'b1;
                    session_next = 1'b0;
                end
            end
        end
        res_next.packet_count = count_next;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item_valid && item_ready)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_item_reg <= item;
    end

    // session state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg  <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= XMODEM_SEED;
            soh_reg      <= 1'b0;
            trail_hi_reg <= '0;
            count_reg    <= '0;
            rem_reg      <= '0;
            off_reg      <= '0;
        end
        else if (s1_fire)
        begin
            session_reg  <= session_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            soh_reg      <= soh_next;
            trail_hi_reg <= trail_hi_next;
            count_reg    <= count_next;
            rem_reg      <= rem_next;
            off_reg      <= off_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_answer)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_answer)
            out_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
